FILE: design/assert_macros.svh
// Assertion macros used by the flute voice top level.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define WFS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define WFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WFS_ASSERT_IMPL(label, ante, cons)
`define WFS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/wfs_pkg.sv
// Package for the waveguide flute voice: sizes, fixed-point constants,
// the vibrato sine table, state codes and helper functions. No dependencies.
package wfs_pkg;

  localparam int LINE_DEPTH       = 4096;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int ADDR_W           = $clog2(LINE_DEPTH);
  localparam int SINE_W           = $clog2(SINE_TABLE_DEPTH);
  localparam int LEN_W            = 20;
  localparam int PROD_W           = 43;

  localparam int THRESHOLD   = 33;
  localparam int JET_OFFSET  = 1638;
  localparam int NOISE_GAIN  = 393;
  localparam int END_REFL    = -24576;
  localparam int CUBIC_LIMIT = 26214;
  localparam int LP_IN       = 9830;
  localparam int LP_KEEP     = 22938;
  localparam int DC_KEEP     = 32604;
  localparam int DC_IN_SCALE = 256 * 164;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [31:0] LEN_MIN   = 32'd512;
  localparam logic [31:0] LEN_MAX   = 32'((LINE_DEPTH - 1) * 256);

  // Register indexes
  localparam logic [2:0] REG_BORE_LEN  = 3'd0;
  localparam logic [2:0] REG_JET_LEN   = 3'd1;
  localparam logic [2:0] REG_VIB_INC   = 3'd2;
  localparam logic [2:0] REG_VIB_DEPTH = 3'd3;
  localparam logic [2:0] REG_SEED      = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VIB, ST_NZ1, ST_NZ2, ST_REFL, ST_JR2, ST_JM1, ST_C1, ST_C2,
    ST_LP1, ST_LP2, ST_BW, ST_BR2, ST_BM1, ST_D1, ST_D2, ST_OUT
  } state_t;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

  // sin(pi/2 * u), u in Q16, result Q16
  function automatic longint quarter_sine(longint u);
    longint u2;
    longint p;
    u2 = (u * u) >>> 16;
    p  = 5223 - ((u2 * 307) >>> 16);
    p  = 42334 - ((u2 * p) >>> 16);
    p  = 102944 - ((u2 * p) >>> 16);
    return (u * p) >>> 16;
  endfunction

  // Build the whole table at elaboration
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint t;
    longint q;
    longint f;
    longint s;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t = (longint'(i) * 262144) / SINE_TABLE_DEPTH;
      q = (t >>> 16) & 3;
      f = t & 65535;
      s = quarter_sine(q[0] ? 65536 - f : f) >>> 1;
      if (s > 32767) s = 32767;
      tab[i] = 16'(q[1] ? -s : s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [15:0] sat16(logic signed [31:0] x);
    if (x > 32'sd32767) return 16'sd32767;
    if (x < -32'sd32768) return -16'sd32768;
    return x[15:0];
  endfunction

endpackage

FILE: design/wfs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/waveguide_flute_synth_unit.sv
// Top level of the waveguide flute voice: sequencer, shared multiplier,
// config registers, and two delay lines. Uses wfs_pkg, wfs_ram, assert_macros.svh.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | in_tdata[14:0] pressure
//  out_    | out | out_tvalid / out_tready| out_tdata[15:0] sample
//  cfg_    | in  | APB psel/penable       | paddr[4:2] register index, pwdata
//
// A quiet item (pressure below threshold) gives its zero result in the next cycle.
// Any other item walks 16 sequencer steps around one shared multiplier and the
// single read port of each delay RAM; its result is registered when the last step
// finds the output slot free, and the sequencer then returns to idle for the next item.
// Reset is synchronous; the delay RAMs are not cleared: entries not yet written
// since reset read as zero through a wrap flag on the shared write index.
// The next item is taken only when the sequencer is idle and the output slot is free;
// a stalled output holds the sequencer in its last step.
`include "assert_macros.svh"
module waveguide_flute_synth_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [14:0] pressure, [15] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wfs_pkg::*;

  state_t state_r, state_nxt;

  logic [19:0] bore_len_r, jet_len_r;
  logic [15:0] vib_inc_r;
  logic [14:0] vib_depth_r;
  logic [31:0] seed_r;

  logic [ADDR_W-1:0] wi_r, wi_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic signed [15:0] lp_r, lp_nxt;
  logic signed [23:0] dc_r, dc_nxt;
  logic signed [15:0] bf_r, bf_nxt;
  logic [23:0] phase_r;
  logic [31:0] lfsr_r;

  logic [14:0] p_r;
  logic signed [15:0] vib_r, vib_nxt, tmp_r, tmp_nxt, nz_r, nz_nxt, refl_r, refl_nxt;
  logic signed [15:0] jet_r, jet_nxt, cub_r, cub_nxt;
  logic signed [16:0] sq_r, sq_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic v_r, v_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [PROD_W-1:0] mp;

  logic jet_we, bore_we;
  logic [15:0] ram_wdata;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] jet_rdata, bore_rdata;

  logic in_acc, quiet, cfg_wr, out_free, jet_side;
  logic [31:0] len_c, back_c;
  logic [7:0] fr;
  logic [ADDR_W-1:0] i1, i2;
  logic signed [15:0] dm;
  logic signed [18:0] x_sum;
  logic signed [17:0] cu_diff;
  logic signed [16:0] fin;
  logic signed [PROD_W-1:0] sum_w;
  logic signed [16:0] y_diff;
  logic [31:0] lfsr_step;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign quiet      = in_tdata[14:0] < 15'(THRESHOLD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Read back register values
  always_comb begin
    case (cfg_paddr[4:2])
      REG_BORE_LEN:  cfg_prdata = {12'd0, bore_len_r};
      REG_JET_LEN:   cfg_prdata = {12'd0, jet_len_r};
      REG_VIB_INC:   cfg_prdata = {16'd0, vib_inc_r};
      REG_VIB_DEPTH: cfg_prdata = {17'd0, vib_depth_r};
      REG_SEED:      cfg_prdata = seed_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Step the noise LFSR
  always_comb begin
    lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_MASK) : (lfsr_r >> 1);
    if (lfsr_step == 32'd0) lfsr_step = 32'd1;
  end

  // Clamp the delay length, derive integer tap and fraction
  always_comb begin
    jet_side = (state_r == ST_REFL) || (state_r == ST_JR2) || (state_r == ST_JM1);
    len_c = {12'd0, jet_side ? jet_len_r : bore_len_r};
    if (len_c < LEN_MIN) len_c = LEN_MIN;
    if (len_c > LEN_MAX) len_c = LEN_MAX;
    back_c = (len_c + 32'd255) >> 8;
    fr = 8'(9'd256 - {1'b0, len_c[7:0]});
    i1 = wi_r - back_c[ADDR_W-1:0];
    i2 = i1 + ADDR_W'(1);
    dm = v_r ? $signed(jet_side ? jet_rdata : bore_rdata) : 16'sd0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && !quiet) state_nxt = ST_VIB;
      ST_VIB:  state_nxt = ST_NZ1;
      ST_NZ1:  state_nxt = ST_NZ2;
      ST_NZ2:  state_nxt = ST_REFL;
      ST_REFL: state_nxt = ST_JR2;
      ST_JR2:  state_nxt = ST_JM1;
      ST_JM1:  state_nxt = ST_C1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_LP1;
      ST_LP1:  state_nxt = ST_LP2;
      ST_LP2:  state_nxt = ST_BW;
      ST_BW:   state_nxt = ST_BR2;
      ST_BR2:  state_nxt = ST_BM1;
      ST_BM1:  state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath: multiplier operands, RAM controls and next values per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    jet_we = 1'b0;
    bore_we = 1'b0;
    ram_wdata = '0;
    raddr = i1;
    vib_nxt = vib_r; tmp_nxt = tmp_r; nz_nxt = nz_r; refl_nxt = refl_r;
    jet_nxt = jet_r; sq_nxt = sq_r; cub_nxt = cub_r; acc_nxt = acc_r;
    lp_nxt = lp_r; dc_nxt = dc_r; bf_nxt = bf_r; wi_nxt = wi_r; wrapped_nxt = wrapped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    x_sum = '0; cu_diff = '0; fin = '0; sum_w = '0; y_diff = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && quiet) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = 16'd0;
        end
      end
      ST_VIB: begin
        mul_a = 25'(SINE_TAB[phase_r[23 -: SINE_W]]);
        mul_b = 18'($signed({1'b0, vib_depth_r}));
        vib_nxt = 16'(mp >>> 15);
      end
      ST_NZ1: begin
        mul_a = 25'($signed({~lfsr_r[31], lfsr_r[30:16]}));
        mul_b = 18'($signed({1'b0, p_r}));
        tmp_nxt = 16'(mp >>> 15);
      end
      ST_NZ2: begin
        mul_a = 25'(tmp_r);
        mul_b = 18'(NOISE_GAIN);
        nz_nxt = 16'(mp >>> 15);
      end
      ST_REFL: begin
        // Form the jet input, write it and fetch the first jet tap
        mul_a = 25'(bf_r);
        mul_b = 18'(END_REFL);
        refl_nxt = 16'(mp >>> 15);
        x_sum = 19'($signed({1'b0, p_r})) + 19'(nz_r) + 19'(vib_r) - 19'(bf_r >>> 1)
              + 19'(JET_OFFSET);
        jet_we = 1'b1;
        ram_wdata = sat16(32'(x_sum));
        raddr = i1;
      end
      ST_JR2: begin
        raddr = i2;
        mul_a = 25'(dm);
        mul_b = 18'(9'd256 - {1'b0, fr});
        acc_nxt = mp;
      end
      ST_JM1: begin
        mul_a = 25'(dm);
        mul_b = 18'({1'b0, fr});
        sum_w = acc_r + mp;
        jet_nxt = 16'(sum_w >>> 8);
      end
      ST_C1: begin
        mul_a = 25'(jet_r);
        mul_b = 18'(jet_r);
        sq_nxt = 17'(mp >>> 15);
      end
      ST_C2: begin
        mul_a = 25'(sq_r);
        mul_b = 18'(jet_r);
        cu_diff = 18'(mp >>> 15) - 18'(jet_r);
        if (cu_diff > 18'(CUBIC_LIMIT)) cub_nxt = 16'(CUBIC_LIMIT);
        else if (cu_diff < -18'(CUBIC_LIMIT)) cub_nxt = -16'(CUBIC_LIMIT);
        else cub_nxt = cu_diff[15:0];
      end
      ST_LP1: begin
        fin = 17'(cub_r) + 17'(refl_r);
        mul_a = 25'(fin);
        mul_b = 18'(LP_IN);
        acc_nxt = mp;
      end
      ST_LP2: begin
        mul_a = 25'(lp_r);
        mul_b = 18'(LP_KEEP);
        sum_w = acc_r + mp;
        lp_nxt = sat16(32'(sum_w >>> 15));
      end
      ST_BW: begin
        bore_we = 1'b1;
        ram_wdata = lp_r;
        raddr = i1;
      end
      ST_BR2: begin
        raddr = i2;
        mul_a = 25'(dm);
        mul_b = 18'(9'd256 - {1'b0, fr});
        acc_nxt = mp;
      end
      ST_BM1: begin
        // Finish bore tap, advance the shared write index
        mul_a = 25'(dm);
        mul_b = 18'({1'b0, fr});
        sum_w = acc_r + mp;
        bf_nxt = 16'(sum_w >>> 8);
        wi_nxt = wi_r + ADDR_W'(1);
        if (wi_r == ADDR_W'(LINE_DEPTH - 1)) wrapped_nxt = 1'b1;
      end
      ST_D1: begin
        mul_a = 25'(dc_r);
        mul_b = 18'(DC_KEEP);
        acc_nxt = mp;
      end
      ST_D2: begin
        mul_a = 25'(bf_r);
        mul_b = 18'(DC_IN_SCALE);
        sum_w = acc_r + mp;
        dc_nxt = 24'(sum_w >>> 15);
      end
      ST_OUT: begin
        if (out_free) begin
          y_diff = 17'(bf_r) - 17'(dc_r >>> 8);
          out_valid_nxt = 1'b1;
          out_data_nxt = sat16(32'(y_diff >>> 1));
        end
      end
      default: ;
    endcase
    v_nxt = wrapped_r || (raddr < wi_r);
  end

  // Full-width signed product
  assign mp = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bore_len_r <= 20'd27671;
      jet_len_r <= 20'd13707;
      vib_inc_r <= 16'd1922;
      vib_depth_r <= 15'd492;
      seed_r <= 32'd1;
      wi_r <= '0;
      wrapped_r <= 1'b0;
      lp_r <= '0;
      dc_r <= '0;
      bf_r <= '0;
      phase_r <= '0;
      lfsr_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wi_r <= wi_nxt;
      wrapped_r <= wrapped_nxt;
      lp_r <= lp_nxt;
      dc_r <= dc_nxt;
      bf_r <= bf_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc && !quiet) begin
        phase_r <= phase_r + {8'd0, vib_inc_r};
      end
      // Load the seed, else step the LFSR once per sounding item
      if (cfg_wr && cfg_paddr[4:2] == REG_SEED) begin
        lfsr_r <= (cfg_pwdata == 32'd0) ? 32'd1 : cfg_pwdata;
      end else if (in_acc && !quiet) begin
        lfsr_r <= lfsr_step;
      end
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_BORE_LEN:  bore_len_r <= cfg_pwdata[19:0];
          REG_JET_LEN:   jet_len_r <= cfg_pwdata[19:0];
          REG_VIB_INC:   vib_inc_r <= cfg_pwdata[15:0];
          REG_VIB_DEPTH: vib_depth_r <= cfg_pwdata[14:0];
          REG_SEED:      seed_r <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) p_r <= in_tdata[14:0];
    vib_r <= vib_nxt; tmp_r <= tmp_nxt; nz_r <= nz_nxt; refl_r <= refl_nxt;
    jet_r <= jet_nxt; sq_r <= sq_nxt; cub_r <= cub_nxt; acc_r <= acc_nxt;
    v_r <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  wfs_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_jet_ram (
    .clk(clk), .we(jet_we), .waddr(wi_r), .wdata(ram_wdata),
    .raddr(raddr), .rdata(jet_rdata)
  );

  wfs_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_bore_ram (
    .clk(clk), .we(bore_we), .waddr(wi_r), .wdata(ram_wdata),
    .raddr(raddr), .rdata(bore_rdata)
  );

  `WFS_ASSERT_NEXT(a_active_starts, in_acc && !quiet, state_r == ST_VIB)
  `WFS_ASSERT_NEXT(a_quiet_zero, in_acc && quiet, out_tvalid && out_tdata == 16'd0)
  `WFS_ASSERT_NEXT(a_out_loads, state_r == ST_OUT && out_free, out_tvalid && state_r == ST_IDLE)
  `WFS_ASSERT_IMPL(a_one_write, 1'b1, $onehot0({jet_we, bore_we}))
endmodule
